>>> rtl/rgbled_pkg.sv
// Shared types, register codes and widths.
package rgbled_pkg;

	localparam int PHASE_TABLE_SIZE = 256;
	localparam int PHASE_BITS       = $clog2(PHASE_TABLE_SIZE);

	localparam int ADV_W   = 10;
	localparam int TIME_W  = 32;
	localparam int DIVR_W  = 16;
	localparam int CHAN_W  = 8;
	localparam int COLOR_W = 24;
	localparam int ENTRY_W = 9;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int CNT_W   = $clog2(TIME_W);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE          = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK_COUNT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BREATH_PERIOD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RESTORE_COLOR = 3'd5;

	typedef enum logic [1:0] {
		MODE_OFF    = 2'd0,
		MODE_SOLID  = 2'd1,
		MODE_BLINK  = 2'd2,
		MODE_BREATH = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_PHASE,
		ST_LOOKUP,
		ST_FINISH
	} state_t;

	// divider controls: load operands, take one step, shift zeros into the remainder
	typedef struct packed {
		logic load;
		logic step;
		logic zero_in;
	} div_ctl_t;

endpackage

>>> rtl/rgbled_tick_if.sv
// Tick channel: valid/ready handshake with the elapsed milliseconds.
interface rgbled_tick_if;
	import rgbled_pkg::*;

	logic             valid;
	logic             ready;
	logic [ADV_W-1:0] advance_ms;

	modport source (output valid, output advance_ms, input ready);
	modport sink (input valid, input advance_ms, output ready);
endinterface

>>> rtl/rgbled_color_if.sv
// Colour channel: valid/ready handshake with the LED drive levels.
interface rgbled_color_if;
	import rgbled_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;
	logic              blink_done;

	modport source (output valid, output red, output green, output blue, output blink_done,
		input ready);
	modport sink (input valid, input red, input green, input blue, input blink_done,
		output ready);
endinterface

>>> rtl/rgbled_div.sv
// Restoring divider, one quotient bit per step, dividend shifted out as quotient shifts in.
module rgbled_div (
	input  logic                           clk,
	input  rgbled_pkg::div_ctl_t           ctl,
	input  logic [rgbled_pkg::TIME_W-1:0]  dividend,
	input  logic [rgbled_pkg::DIVR_W-1:0]  divisor,
	output logic [rgbled_pkg::TIME_W-1:0]  quotient
);
	import rgbled_pkg::*;

	logic [TIME_W-1:0] dvd_q;
	logic [DIVR_W-1:0] rem_q;
	logic [DIVR_W-1:0] dsr_q;
	logic [DIVR_W:0]   trial;
	logic [DIVR_W:0]   diff;
	logic              qbit;

	always_comb begin
		// a step past the dividend's bits keeps long division going with zeros
		trial = {rem_q, (ctl.zero_in ? 1'b0 : dvd_q[TIME_W-1])};
		diff  = trial - {1'b0, dsr_q};
		qbit  = (trial >= {1'b0, dsr_q});
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (ctl.step) begin
			dvd_q <= {dvd_q[TIME_W-2:0], qbit};
			rem_q <= qbit ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
		end
	end

	assign quotient = dvd_q;

endmodule

>>> rtl/rgb_led_blink_breathe_pattern.sv
// Top level of the RGB LED blink and breathing pattern generator.
// Each tick transfer adds advance_ms to a saturating millisecond counter and produces one colour
// transfer. Off and solid show the colour register; blink alternates colour and black every
// blink_half_ms and, with a nonzero blink_count, switches to restore_color with blink_done set
// after that many flashes; breathing scales the colour by 0.3+0.7*(0.5-0.5cos) from a 256-entry
// table. A write to any of the six registers clears the counter and the done flag; writes to
// other indexes are ignored. All divisions go through one shared restoring divider that yields
// one bit a cycle. In off and solid an item goes straight from idle to the finish state; blink
// takes 32 divider steps for elapsed/half, and breathing takes 32 steps for elapsed mod period,
// 8 more for the table index and one table read. The block takes no tick while busy; a finished
// colour sits in an output register so the next tick can be taken while it waits.
module rgb_led_blink_breathe_pattern (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rgbled_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [rgbled_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	rgbled_tick_if.sink                         tick,
	rgbled_color_if.source                      led
);
	import rgbled_pkg::*;

	// configuration
	mode_t              mode_q;
	logic [COLOR_W-1:0] color_q;
	logic [DIVR_W-1:0]  blink_half_q;
	logic [7:0]         blink_count_q;
	logic [DIVR_W-1:0]  breath_period_q;
	logic [COLOR_W-1:0] restore_color_q;
	logic               cfg_hit;

	// sequencer and pattern state
	state_t             state_q, state_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [TIME_W-1:0]  elapsed_q;
	logic               finished_q;
	logic [ENTRY_W-1:0] entry_q;

	// output register
	logic               out_valid_q;
	logic [CHAN_W-1:0]  red_q, green_q, blue_q;
	logic               done_q;

	logic               tick_xfer;
	logic               out_load;
	logic [TIME_W:0]    sum;
	logic [TIME_W-1:0]  elapsed_next;
	logic [DIVR_W-1:0]  divisor;
	div_ctl_t           div_ctl;
	logic [TIME_W-1:0]  quotient;

	logic               fin_next;
	logic [CHAN_W-1:0]  red_d, green_d, blue_d;
	logic [CHAN_W+ENTRY_W-1:0] prod_r, prod_g, prod_b;

	// breathing gain table, Q1.8
	logic [ENTRY_W-1:0] breath_tbl [PHASE_TABLE_SIZE];

	// 0.3 + 0.7*sin^2, sine from the Bhaskara approximation in Q16, rounded half up
	for (genvar k = 0; k < PHASE_TABLE_SIZE; k++) begin : g_breath
		localparam longint unsigned S     = 64'(PHASE_TABLE_SIZE);
		localparam longint unsigned P     = 64'(k) * (S - 64'(k));
		localparam longint unsigned DEN   = 64'd5 * S * S - 64'd4 * P;
		localparam longint unsigned S16   = ((64'd16 * P) << 16) / DEN;
		localparam longint unsigned NUM   = 64'd256 * (64'd3 * (64'd1 << 32) + 64'd7 * S16 * S16);
		localparam longint unsigned D     = 64'd10 << 32;
		localparam longint unsigned ENTRY = (64'd2 * NUM + D) / (64'd2 * D);
		assign breath_tbl[k] = ENTRY_W'(ENTRY);
	end

	assign cfg_hit = cfg_we && (cfg_idx <= REG_RESTORE_COLOR);

	// saturating time update
	always_comb begin
		sum          = {1'b0, elapsed_q} + (TIME_W+1)'(tick.advance_ms);
		elapsed_next = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
	end

	// zero half or period behaves as one
	always_comb begin
		if (mode_q == MODE_BLINK)
			divisor = (blink_half_q == '0) ? DIVR_W'(1) : blink_half_q;
		else
			divisor = (breath_period_q == '0) ? DIVR_W'(1) : breath_period_q;
	end

	rgbled_div u_div (
		.clk      (clk),
		.ctl      (div_ctl),
		.dividend (elapsed_next),
		.divisor  (divisor),
		.quotient (quotient)
	);

	// sequencer
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		div_ctl    = '0;
		tick.ready = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				tick.ready = 1'b1;
				if (tick.valid) begin
					div_ctl.load = 1'b1;
					if (mode_q == MODE_BLINK || mode_q == MODE_BREATH) begin
						state_d = ST_DIV;
						cnt_d   = CNT_W'(TIME_W - 1);
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_DIV: begin
				div_ctl.step = 1'b1;
				if (cnt_q == '0) begin
					if (mode_q == MODE_BREATH) begin
						state_d = ST_PHASE;
						cnt_d   = CNT_W'(PHASE_BITS - 1);
					end else begin
						state_d = ST_FINISH;
					end
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_PHASE: begin
				// remainder from the first pass times 2^PHASE_BITS over the period
				div_ctl.step    = 1'b1;
				div_ctl.zero_in = 1'b1;
				if (cnt_q == '0)
					state_d = ST_LOOKUP;
				else
					cnt_d = cnt_q - 1'b1;
			end
			ST_LOOKUP: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || led.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign tick_xfer = tick.valid && tick.ready;

	// colour of the finished item
	always_comb begin
		prod_r = (CHAN_W+ENTRY_W)'(color_q[23:16]) * (CHAN_W+ENTRY_W)'(entry_q);
		prod_g = (CHAN_W+ENTRY_W)'(color_q[15:8]) * (CHAN_W+ENTRY_W)'(entry_q);
		prod_b = (CHAN_W+ENTRY_W)'(color_q[7:0]) * (CHAN_W+ENTRY_W)'(entry_q);

		// flash count reached once the half count passes twice the count
		fin_next = finished_q || (mode_q == MODE_BLINK && blink_count_q != '0 &&
			quotient >= TIME_W'({blink_count_q, 1'b0}));

		red_d   = color_q[23:16];
		green_d = color_q[15:8];
		blue_d  = color_q[7:0];
		unique case (mode_q)
			MODE_BLINK: begin
				if (quotient[0]) begin
					red_d   = '0;
					green_d = '0;
					blue_d  = '0;
				end
			end
			MODE_BREATH: begin
				red_d   = prod_r[CHAN_W+7:8];
				green_d = prod_g[CHAN_W+7:8];
				blue_d  = prod_b[CHAN_W+7:8];
			end
			default: begin
			end
		endcase
		if (fin_next) begin
			red_d   = restore_color_q[23:16];
			green_d = restore_color_q[15:8];
			blue_d  = restore_color_q[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			cnt_q           <= '0;
			elapsed_q       <= '0;
			finished_q      <= 1'b0;
			out_valid_q     <= 1'b0;
			mode_q          <= MODE_OFF;
			color_q         <= '0;
			blink_half_q    <= DIVR_W'(500);
			blink_count_q   <= '0;
			breath_period_q <= DIVR_W'(2000);
			restore_color_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;

			if (out_load)
				out_valid_q <= 1'b1;
			else if (led.ready)
				out_valid_q <= 1'b0;

			if (cfg_hit) begin
				elapsed_q  <= '0;
				finished_q <= 1'b0;
			end else begin
				if (tick_xfer)
					elapsed_q <= elapsed_next;
				if (out_load)
					finished_q <= fin_next;
			end

			if (cfg_we) begin
				unique case (cfg_idx)
					REG_MODE:          mode_q          <= mode_t'(cfg_wdata[1:0]);
					REG_COLOR:         color_q         <= cfg_wdata[COLOR_W-1:0];
					REG_BLINK_HALF:    blink_half_q    <= cfg_wdata[DIVR_W-1:0];
					REG_BLINK_COUNT:   blink_count_q   <= cfg_wdata[7:0];
					REG_BREATH_PERIOD: breath_period_q <= cfg_wdata[DIVR_W-1:0];
					REG_RESTORE_COLOR: restore_color_q <= cfg_wdata[COLOR_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_LOOKUP)
			entry_q <= breath_tbl[quotient[PHASE_BITS-1:0]];
		if (out_load) begin
			red_q   <= red_d;
			green_q <= green_d;
			blue_q  <= blue_d;
			done_q  <= fin_next;
		end
	end

	assign led.valid      = out_valid_q;
	assign led.red        = red_q;
	assign led.green      = green_q;
	assign led.blue       = blue_q;
	assign led.blink_done = done_q;

endmodule

>>> tb/rgb_led_blink_breathe_pattern_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the RGB LED blink and breathing pattern generator.
module rgb_led_blink_breathe_pattern_tb;
	import rgbled_pkg::*;

	// a run with no transfer for this many cycles is hung
	localparam int unsigned STALL_LIMIT  = 4000;
	// settle time after the last colour, well past the slowest item (breathing)
	localparam int unsigned TAIL_CYCLES  = 100;
	localparam int unsigned TOTAL_TICKS  = 850;

	// indexes past the register file; writes there must leave time and done alone
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	// receiver back-pressure styles
	localparam logic [1:0] RX_OPEN = 2'd0;
	localparam logic [1:0] RX_COIN = 2'd1;
	localparam logic [1:0] RX_COMB = 2'd2;
	localparam logic [1:0] RX_HOLD = 2'd3;

	// packed in port order so a 24-bit colour word plus the done bit fills it directly
	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              blink_done;
	} led_colour_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  tick_valid = 1'b0;
	logic [ADV_W-1:0]      tick_adv   = '0;
	logic                  led_ready  = 1'b0;

	rgbled_tick_if  tick_ch ();
	rgbled_color_if led_ch ();

	assign tick_ch.valid      = tick_valid;
	assign tick_ch.advance_ms = tick_adv;
	assign led_ch.ready       = led_ready;

	rgb_led_blink_breathe_pattern uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.tick      (tick_ch),
		.led       (led_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow copy of the block: registers at their reset values, the
	// millisecond counter and the finished flag.
	// ------------------------------------------------------------------
	mode_t              sh_mode     = MODE_OFF;
	logic [COLOR_W-1:0] sh_colour   = '0;
	logic [DIVR_W-1:0]  sh_half     = 16'd500;
	logic [7:0]         sh_count    = '0;
	logic [DIVR_W-1:0]  sh_period   = 16'd2000;
	logic [COLOR_W-1:0] sh_restore  = '0;
	logic [TIME_W-1:0]  sh_elapsed  = '0;
	logic               sh_finished = 1'b0;

	logic [ADV_W-1:0] pending_ticks [$];   // ticks not yet offered to the block
	led_colour_t      colour_due    [$];   // predicted colours, oldest first

	int unsigned ticks_queued = 0;
	int unsigned ticks_taken  = 0;
	int unsigned fault_count  = 0;
	int unsigned quiet_cycles = 0;
	int unsigned burst_left   = 0;
	int unsigned gap_left     = 0;
	int unsigned rx_cycle     = 0;
	int unsigned rx_hold      = 0;
	logic [1:0]  rx_style     = RX_OPEN;

	// Breathing gain in Q1.8: 0.3 + 0.7*sin^2(pi*idx/N), with the sine taken from
	// the Bhaskara approximation in Q16 and the result rounded half up.
	function automatic logic [ENTRY_W-1:0] breath_gain(input logic [PHASE_BITS-1:0] idx);
		longint unsigned n, i, p, den, sine_q16, num, d;
		n        = 64'(PHASE_TABLE_SIZE);
		i        = 64'(idx);
		p        = i * (n - i);
		den      = 64'd5 * n * n - 64'd4 * p;
		sine_q16 = ((64'd16 * p) << 16) / den;
		num      = 64'd256 * (64'd3 * (64'd1 << 32) + 64'd7 * sine_q16 * sine_q16);
		d        = 64'd10 << 32;
		return ENTRY_W'((64'd2 * num + d) / (64'd2 * d));
	endfunction

	// gain tops out at 256, so the product never leaves 8 bits after the shift
	function automatic logic [CHAN_W-1:0] scale_level(input logic [CHAN_W-1:0] level,
		input logic [ENTRY_W-1:0] gain);
		logic [16:0] prod;
		prod = level * gain;
		return prod[15:8];
	endfunction

	// Advances the shadow counter by one tick and returns the colour it yields.
	function automatic led_colour_t next_colour(input logic [ADV_W-1:0] adv);
		led_colour_t       res;
		logic [TIME_W:0]   sum;
		logic [TIME_W-1:0] half_len, halves, per;
		logic [63:0]       phase_idx;
		logic [ENTRY_W-1:0] gain;
		// counter saturates rather than wrapping
		sum        = {1'b0, sh_elapsed} + (TIME_W+1)'(adv);
		sh_elapsed = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
		res        = {sh_colour, 1'b0};
		if (sh_mode == MODE_BLINK) begin
			half_len = (sh_half == '0) ? 32'd1 : 32'(sh_half);
			halves   = sh_elapsed / half_len;
			// finite blinking: done after count flashes, i.e. 2*count halves
			if (sh_count != '0 && halves >= {23'd0, sh_count, 1'b0})
				sh_finished = 1'b1;
			if (!sh_finished && halves[0])
				{res.red, res.green, res.blue} = '0;
		end else if (sh_mode == MODE_BREATH) begin
			per       = (sh_period == '0) ? 32'd1 : 32'(sh_period);
			phase_idx = (64'(sh_elapsed % per) * 64'(PHASE_TABLE_SIZE)) / 64'(per);
			gain      = breath_gain(PHASE_BITS'(phase_idx));
			res.red   = scale_level(res.red, gain);
			res.green = scale_level(res.green, gain);
			res.blue  = scale_level(res.blue, gain);
		end
		if (sh_finished)
			res = {sh_restore, 1'b1};
		return res;
	endfunction

	function automatic void check_field(input string field, input logic [CHAN_W-1:0] want,
		input logic [CHAN_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			fault_count++;
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Only called with the block idle, so the shadow can be updated at once.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_MODE:          sh_mode    = mode_t'(data[1:0]);
			REG_COLOR:         sh_colour  = data[COLOR_W-1:0];
			REG_BLINK_HALF:    sh_half    = data[DIVR_W-1:0];
			REG_BLINK_COUNT:   sh_count   = data[7:0];
			REG_BREATH_PERIOD: sh_period  = data[DIVR_W-1:0];
			REG_RESTORE_COLOR: sh_restore = data[COLOR_W-1:0];
			default: ;
		endcase
		// any real register write restarts the pattern
		if (idx <= REG_RESTORE_COLOR) begin
			sh_elapsed  = '0;
			sh_finished = 1'b0;
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_tick(input logic [ADV_W-1:0] adv);
		pending_ticks.push_back(adv);
		ticks_queued++;
	endtask

	// Sender holds off until every tick is taken and every colour is back.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (ticks_taken != ticks_queued || colour_due.size() != 0);
	endtask

	function automatic logic [ADV_W-1:0] rand_advance();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3, 4: return ADV_W'($urandom_range(0, 1023));
			default: return ADV_W'($urandom_range(1, 64));
		endcase
	endfunction

	// half interval or period, with the zero-acts-as-one and full-scale extremes
	function automatic logic [DIVR_W-1:0] pick_span(input int unsigned typical_max);
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return 16'd1;
			2:       return '1;
			3:       return DIVR_W'($urandom_range(1, 65535));
			default: return DIVR_W'($urandom_range(1, typical_max));
		endcase
	endfunction

	function automatic logic [COLOR_W-1:0] pick_colour();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			default: return COLOR_W'($urandom);
		endcase
	endfunction

	function automatic mode_t pick_mode();
		case ($urandom_range(0, 9))
			0:             return MODE_OFF;
			1:             return MODE_SOLID;
			2, 3, 4, 5:    return MODE_BLINK;
			default:       return MODE_BREATH;
		endcase
	endfunction

	function automatic logic [7:0] pick_count();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			default: return 8'($urandom_range(1, 6));
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Sequencer: directed cases, then randomly configured phases. The
	// registers are only touched once the block has drained.
	// ------------------------------------------------------------------
	initial begin
		int unsigned n;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset defaults: off mode, black
		queue_tick('0);
		queue_tick('1);
		wait_idle();

		// solid white; junk above the mode bits must be dropped
		write_reg(REG_COLOR, 24'hFFFFFF);
		write_reg(REG_MODE, {22'h3FFFFF, MODE_SOLID});
		queue_tick('1);
		queue_tick('0);
		wait_idle();

		// off shows the colour register just like solid
		write_reg(REG_COLOR, 24'h5AA53C);
		write_reg(REG_MODE, {22'd0, MODE_OFF});
		queue_tick(10'd7);
		wait_idle();

		// blink with a zero half (taken as 1 ms) and two flashes, then restore colour
		write_reg(REG_COLOR, 24'hFF8001);
		write_reg(REG_BLINK_HALF, 24'hAB0000);
		write_reg(REG_BLINK_COUNT, 24'd2);
		write_reg(REG_RESTORE_COLOR, 24'h00FF00);
		write_reg(REG_MODE, {22'd0, MODE_BLINK});
		queue_tick('0);
		repeat (5) queue_tick(10'd1);
		wait_idle();

		// endless blink with the longest half
		write_reg(REG_BLINK_HALF, 24'h00FFFF);
		write_reg(REG_BLINK_COUNT, 24'd0);
		queue_tick('1);
		wait_idle();

		// most flashes, shortest half: one big step overshoots the end
		write_reg(REG_BLINK_HALF, 24'd1);
		write_reg(REG_BLINK_COUNT, 24'h0000FF);
		queue_tick('1);
		queue_tick('1);
		wait_idle();

		// breathing, zero period taken as 1 ms
		write_reg(REG_COLOR, 24'hFFFFFF);
		write_reg(REG_BREATH_PERIOD, 24'd0);
		write_reg(REG_MODE, {22'd0, MODE_BREATH});
		queue_tick(10'd3);
		wait_idle();

		// longest period
		write_reg(REG_BREATH_PERIOD, 24'h00FFFF);
		queue_tick('1);
		queue_tick('1);
		wait_idle();

		// period equal to the table size: quarter, peak, three quarters
		write_reg(REG_BREATH_PERIOD, 24'd256);
		repeat (3) queue_tick(10'd64);
		wait_idle();

		// writes beyond the register file leave the counter running
		write_reg(REG_SPARE_LO, 24'hFFFFFF);
		write_reg(REG_SPARE_HI, 24'h000000);
		queue_tick(10'd64);
		wait_idle();

		write_reg(REG_BREATH_PERIOD, 24'd1);
		queue_tick(10'd1);
		wait_idle();

		// random phases: a fresh mix of registers, then a run of ticks
		while (ticks_queued < TOTAL_TICKS) begin
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_MODE, {22'($urandom), pick_mode()});
			if ($urandom_range(0, 1) != 0)
				write_reg(REG_COLOR, pick_colour());
			if ($urandom_range(0, 1) != 0)
				write_reg(REG_BLINK_HALF, {8'($urandom), pick_span(20)});
			if ($urandom_range(0, 1) != 0)
				write_reg(REG_BLINK_COUNT, {16'($urandom), pick_count()});
			if ($urandom_range(0, 1) != 0)
				write_reg(REG_BREATH_PERIOD, {8'($urandom), pick_span(400)});
			if ($urandom_range(0, 1) != 0)
				write_reg(REG_RESTORE_COLOR, pick_colour());
			if ($urandom_range(0, 7) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 24'($urandom));
			n = $urandom_range(5, 50);
			for (int k = 0; k < n; k++) begin
				queue_tick(rand_advance());
				// now and then let everything drain mid-phase
				if (k == n / 2 && $urandom_range(0, 3) == 0)
					wait_idle();
			end
			wait_idle();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (colour_due.size() != 0)
			$error("%0d colour(s) never arrived", colour_due.size());
		if (fault_count == 0 && colour_due.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ------------------------------------------------------------------
	// Tick driver: bursts of random length, random gaps between them, and
	// occasional long runs with no gaps at all. A held item keeps valid high
	// until its transfer.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_valid <= 1'b0;
			tick_adv   <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (tick_valid && tick_ch.ready) begin
				colour_due.push_back(next_colour(tick_adv));
				ticks_taken++;
			end
			if (!tick_valid || tick_ch.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					tick_valid <= 1'b0;
				end else if (pending_ticks.size() != 0) begin
					tick_valid <= 1'b1;
					tick_adv   <= pending_ticks.pop_front();
					if (burst_left != 0)
						burst_left--;
					else if ($urandom_range(0, 3) == 0) begin
						burst_left = $urandom_range(30, 80);
						gap_left   = 0;
					end else begin
						burst_left = $urandom_range(0, 10);
						gap_left   = $urandom_range(1, 12);
					end
				end else begin
					tick_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Colour receiver: the stall style switches periodically between
	// always ready, a biased coin, one cycle in three and long holds.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_ready <= 1'b0;
			rx_cycle  <= 0;
			rx_hold   <= 0;
			rx_style  <= RX_OPEN;
		end else begin
			rx_cycle <= rx_cycle + 1;
			if (rx_cycle % 128 == 0)
				rx_style <= 2'($urandom_range(0, 3));
			case (rx_style)
				RX_OPEN: led_ready <= 1'b1;
				RX_COIN: led_ready <= ($urandom_range(0, 9) < 7);
				RX_COMB: led_ready <= (rx_cycle % 3 == 0);
				default: begin
					if (rx_hold != 0) begin
						rx_hold   <= rx_hold - 1;
						led_ready <= 1'b0;
					end else begin
						led_ready <= 1'b1;
						rx_hold   <= ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : 0;
					end
				end
			endcase
		end
	end

	// Colour monitor: every transfer is matched against the oldest prediction.
	always @(posedge clk) begin
		led_colour_t seen;
		led_colour_t want;
		if (arst_n && led_ch.valid && led_ch.ready) begin
			seen = {led_ch.red, led_ch.green, led_ch.blue, led_ch.blink_done};
			if (colour_due.size() == 0) begin
				$error("colour transfer %h with nothing outstanding", seen);
				fault_count++;
			end else begin
				want = colour_due.pop_front();
				check_field("red", want.red, seen.red);
				check_field("green", want.green, seen.green);
				check_field("blue", want.blue, seen.blue);
				check_field("blink_done", 8'(want.blink_done), 8'(seen.blink_done));
			end
		end
	end

	// Watchdog: too long without any transfer on either channel means a hang.
	always @(posedge clk) begin
		if (!arst_n || (tick_valid && tick_ch.ready) || (led_ch.valid && led_ch.ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_LIMIT) begin
			$error("no transfer for %0d cycles", quiet_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

endmodule
